/* rtl/bfr_pkg.sv */
// Shared types, constants and status codes for the fragment reassembler.
// Used by every module of the block except bfr_ram; depends on nothing else.
package bfr_pkg;

  // Message storage geometry.
  localparam int MAX_MESSAGE_BYTES = 1024;
  localparam int MSG_AW            = $clog2(MAX_MESSAGE_BYTES);
  localparam int STORE_DEPTH       = 2 * MAX_MESSAGE_BYTES;
  localparam int STORE_AW          = $clog2(STORE_DEPTH);

  // Field widths.
  localparam int LEN_W  = 11;
  localparam int CNT_W  = 11;
  localparam int BYTE_W = 8;
  localparam int STAT_W = 4;
  localparam int RADR_W = 10;

  // Packet header layout.
  localparam int FIRST_HEADER = 6;
  localparam int CONT_HEADER  = 3;
  localparam logic [BYTE_W-1:0] FLAGS_NONE = 8'h00;
  localparam logic [CNT_W-1:0]  COUNT_MAX  = 11'd2047;
  localparam logic [LEN_W-1:0]  MAX_LEN_RESET = 11'd1024;

  // Result queue depth between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Item kinds.
  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  // Packet status codes.
  localparam logic [STAT_W-1:0] ST_INCOMPLETE    = 4'd0;
  localparam logic [STAT_W-1:0] ST_COMPLETE      = 4'd1;
  localparam logic [STAT_W-1:0] ST_SHORT         = 4'd2;
  localparam logic [STAT_W-1:0] ST_FLAGS         = 4'd3;
  localparam logic [STAT_W-1:0] ST_LENGTH        = 4'd4;
  localparam logic [STAT_W-1:0] ST_FIRST_OVERRUN = 4'd5;
  localparam logic [STAT_W-1:0] ST_IDLE          = 4'd6;
  localparam logic [STAT_W-1:0] ST_ID            = 4'd7;
  localparam logic [STAT_W-1:0] ST_OFFSET        = 4'd8;
  localparam logic [STAT_W-1:0] ST_EMPTY         = 4'd9;
  localparam logic [STAT_W-1:0] ST_OVERRUN       = 4'd10;

  // One input item.
  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_packet;
    logic [RADR_W-1:0] read_address;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic              result_kind;
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  message_length;
    logic [BYTE_W-1:0] read_data;
  } out_item_t;

  // Memory access issued by the front part.
  typedef struct packed {
    logic                we;
    logic [STORE_AW-1:0] waddr;
    logic [BYTE_W-1:0]   wdata;
    logic                re;
    logic [STORE_AW-1:0] raddr;
  } ram_req_t;

endpackage

/* rtl/bfr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Stands alone; no package needed.
module bfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/bfr_front.sv */
// Front part: accepts items, captures headers, tracks the message in flight,
// issues store writes and reads, and forms one result per reporting item.
// Depends on bfr_pkg.
module bfr_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  bfr_pkg::in_item_t      item,
  input  logic                   cfg_we,
  input  logic [bfr_pkg::LEN_W-1:0] cfg_data,
  input  logic [bfr_pkg::BYTE_W-1:0] ram_rdata,
  output bfr_pkg::ram_req_t      ram_req,
  output logic                   pending,
  output logic                   push,
  output bfr_pkg::out_item_t     push_item
);
  import bfr_pkg::*;

  // Architectural state.
  logic [LEN_W-1:0]  max_len;
  logic              in_flight;
  logic [LEN_W-1:0]  expected_length;
  logic [BYTE_W-1:0] message_tag;
  logic [LEN_W-1:0]  received_count;
  logic [CNT_W-1:0]  pkt_cnt;
  logic [BYTE_W-1:0] hdr [FIRST_HEADER];
  logic              active_bank;
  logic [LEN_W-1:0]  completed_length;

  logic              in_flight_next;
  logic [LEN_W-1:0]  expected_length_next;
  logic [BYTE_W-1:0] message_tag_next;
  logic [LEN_W-1:0]  received_count_next;
  logic [CNT_W-1:0]  pkt_cnt_next;
  logic              active_bank_next;
  logic [LEN_W-1:0]  completed_length_next;

  // Result held in registers while the store read completes.
  logic              s1_valid;
  logic              s1_kind;
  logic [STAT_W-1:0] s1_status;
  logic [LEN_W-1:0]  s1_len;
  logic              s1_zero;

  logic              is_pkt;
  logic              is_read;
  logic [BYTE_W-1:0] hdr_new [FIRST_HEADER];
  logic [15:0]       offset;
  logic [15:0]       hlen;
  logic              len_ok;
  logic              first_ok;
  logic              cont_match;
  logic [CNT_W-1:0]  first_pos;
  logic [CNT_W-1:0]  cont_rel;
  logic [12:0]       cont_pos;
  logic [CNT_W-1:0]  size;
  logic [CNT_W-1:0]  payload_first;
  logic [CNT_W-1:0]  payload_cont;
  logic [12:0]       cont_total;
  logic [STAT_W-1:0] status;
  logic [LEN_W-1:0]  len_out;
  logic              read_bank;

  assign is_pkt  = accept && (item.kind == KIND_PACKET);
  assign is_read = accept && (item.kind == KIND_READ);

  // Header view including the byte arriving now.
  always_comb begin
    for (int k = 0; k < FIRST_HEADER; k++) begin
      hdr_new[k] = (is_pkt && pkt_cnt == CNT_W'(k)) ? item.data_byte : hdr[k];
    end
  end

  assign offset = {hdr_new[1], hdr_new[0]};
  assign hlen   = {hdr_new[4], hdr_new[3]};
  assign len_ok = (hlen != 16'd0) && (hlen <= {5'd0, max_len})
                  && (hlen <= 16'(MAX_MESSAGE_BYTES));
  assign first_ok = (offset == 16'd0) && (hdr_new[5] == FLAGS_NONE) && len_ok;
  assign cont_match = in_flight && (offset != 16'd0) && (hdr_new[2] == message_tag)
                      && (offset == {5'd0, received_count});

  // Store write positions for both fragment types.
  assign first_pos = pkt_cnt - CNT_W'(FIRST_HEADER);
  assign cont_rel  = pkt_cnt - CNT_W'(CONT_HEADER);
  assign cont_pos  = {2'd0, received_count} + {2'd0, cont_rel};

  // Saturating packet size after this byte.
  assign size = (pkt_cnt == COUNT_MAX) ? pkt_cnt : pkt_cnt + 1'b1;
  assign payload_first = size - CNT_W'(FIRST_HEADER);
  assign payload_cont  = size - CNT_W'(CONT_HEADER);
  assign cont_total    = {2'd0, received_count} + {2'd0, payload_cont};

  assign read_bank = in_flight ? ~active_bank : active_bank;

  // Store access: one write for a payload byte or one read for a read item.
  always_comb begin
    ram_req = '0;
    ram_req.wdata = item.data_byte;
    if (is_pkt && pkt_cnt >= CNT_W'(FIRST_HEADER) && first_ok
        && {5'd0, first_pos} < hlen) begin
      ram_req.we    = 1'b1;
      ram_req.waddr = {~active_bank, first_pos[MSG_AW-1:0]};
    end else if (is_pkt && pkt_cnt >= CNT_W'(CONT_HEADER) && cont_match
                 && cont_pos < {2'd0, expected_length}
                 && cont_pos < 13'(MAX_MESSAGE_BYTES)) begin
      ram_req.we    = 1'b1;
      ram_req.waddr = {active_bank, cont_pos[MSG_AW-1:0]};
    end
    ram_req.re    = is_read;
    ram_req.raddr = {read_bank, item.read_address[MSG_AW-1:0]};
  end

  // Packet state update and end-of-packet classification.
  always_comb begin
    in_flight_next        = in_flight;
    expected_length_next  = expected_length;
    message_tag_next      = message_tag;
    received_count_next   = received_count;
    active_bank_next      = active_bank;
    completed_length_next = completed_length;
    pkt_cnt_next          = pkt_cnt;
    status                = ST_INCOMPLETE;
    len_out               = '0;
    if (is_pkt) begin
      pkt_cnt_next = size;
      // A valid first header while in flight drops the completed message.
      if (pkt_cnt == CNT_W'(FIRST_HEADER - 1) && in_flight && first_ok) begin
        completed_length_next = '0;
      end
      if (item.end_of_packet) begin
        pkt_cnt_next = '0;
        if (size < CNT_W'(CONT_HEADER)) begin
          status = ST_SHORT;
        end else if (offset == 16'd0) begin
          if (size < CNT_W'(FIRST_HEADER)) begin
            status = ST_SHORT;
          end else if (hdr_new[5] != FLAGS_NONE) begin
            status = ST_FLAGS;
          end else if (!len_ok) begin
            status = ST_LENGTH;
          end else if ({5'd0, payload_first} > hlen) begin
            status = ST_FIRST_OVERRUN;
          end else begin
            if (in_flight) begin
              completed_length_next = '0;
            end
            message_tag_next     = hdr_new[2];
            expected_length_next = hlen[LEN_W-1:0];
            received_count_next  = payload_first;
            active_bank_next     = ~active_bank;
            if ({5'd0, payload_first} == hlen) begin
              in_flight_next        = 1'b0;
              completed_length_next = hlen[LEN_W-1:0];
              len_out               = hlen[LEN_W-1:0];
              status                = ST_COMPLETE;
            end else begin
              in_flight_next = 1'b1;
              status         = ST_INCOMPLETE;
            end
          end
        end else if (!in_flight) begin
          status = ST_IDLE;
        end else if (hdr_new[2] != message_tag) begin
          status           = ST_ID;
          in_flight_next   = 1'b0;
          active_bank_next = ~active_bank;
        end else if (offset != {5'd0, received_count}) begin
          status           = ST_OFFSET;
          in_flight_next   = 1'b0;
          active_bank_next = ~active_bank;
        end else if (payload_cont == '0) begin
          status           = ST_EMPTY;
          in_flight_next   = 1'b0;
          active_bank_next = ~active_bank;
        end else if (cont_total > {2'd0, expected_length}) begin
          status           = ST_OVERRUN;
          in_flight_next   = 1'b0;
          active_bank_next = ~active_bank;
        end else begin
          received_count_next = cont_total[LEN_W-1:0];
          if (cont_total == {2'd0, expected_length}) begin
            in_flight_next        = 1'b0;
            completed_length_next = expected_length;
            len_out               = expected_length;
            status                = ST_COMPLETE;
          end else begin
            status = ST_INCOMPLETE;
          end
        end
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_len          <= MAX_LEN_RESET;
      in_flight        <= 1'b0;
      expected_length  <= '0;
      message_tag      <= '0;
      received_count   <= '0;
      pkt_cnt          <= '0;
      active_bank      <= 1'b0;
      completed_length <= '0;
      for (int k = 0; k < FIRST_HEADER; k++) begin
        hdr[k] <= '0;
      end
    end else begin
      if (cfg_we) begin
        max_len <= cfg_data;
      end
      in_flight        <= in_flight_next;
      expected_length  <= expected_length_next;
      message_tag      <= message_tag_next;
      received_count   <= received_count_next;
      pkt_cnt          <= pkt_cnt_next;
      active_bank      <= active_bank_next;
      completed_length <= completed_length_next;
      for (int k = 0; k < FIRST_HEADER; k++) begin
        hdr[k] <= hdr_new[k];
      end
    end
  end

  // Result stage waiting on the store read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= is_read || (is_pkt && item.end_of_packet);
    end
  end

  always_ff @(posedge clk) begin
    s1_kind   <= item.kind;
    s1_status <= status;
    s1_len    <= len_out;
    s1_zero   <= !({1'b0, item.read_address} < completed_length);
  end

  assign pending = s1_valid;
  assign push    = s1_valid;

  // Merge the read data into the result.
  always_comb begin
    push_item.result_kind = s1_kind;
    if (s1_kind == KIND_READ) begin
      push_item.status         = '0;
      push_item.message_length = '0;
      push_item.read_data      = s1_zero ? '0 : ram_rdata;
    end else begin
      push_item.status         = s1_status;
      push_item.message_length = s1_len;
      push_item.read_data      = '0;
    end
  end

endmodule

/* rtl/bfr_queue.sv */
// Short result queue that decouples the front part from the output stage.
// Depends on bfr_pkg.
module bfr_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  bfr_pkg::out_item_t  push_item,
  input  logic                pop,
  output logic                not_empty,
  output bfr_pkg::out_item_t  head,
  output logic [bfr_pkg::QUEUE_AW:0] level
);
  import bfr_pkg::*;

  out_item_t             entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_AW:0]     count;

  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];
  assign level     = count;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/bfr_back.sv */
// Back part: output register that presents results and holds them under stall.
// Depends on bfr_pkg.
module bfr_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_not_empty,
  input  bfr_pkg::out_item_t q_head,
  output logic               q_pop,
  output logic               result_valid,
  input  logic               result_stall,
  output bfr_pkg::out_item_t result
);
  import bfr_pkg::*;

  logic load;

  // Refill when the register is empty or its transaction completes now.
  assign load  = !result_valid || !result_stall;
  assign q_pop = load && q_not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= q_not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      result <= q_head;
    end
  end

endmodule

/* rtl/ble_fragment_reassembler_unit.sv */
// Fragment reassembler: header parsing, two-bank message store, result path.
// Depends on bfr_pkg, bfr_ram, bfr_front, bfr_queue and bfr_back.
//
// Usage: items enter on item/item_valid/item_stall. A packet byte (kind 0)
// is taken every cycle while item_stall is low; the last byte of a packet (end_of_packet) yields one
// status result. A read item (kind 1) yields one byte of the last completed
// message, or zero beyond its length. Results leave on result/result_valid/
// result_stall in item order. The max_message_length register is written on
// cfg_valid/cfg_ready/cfg_data; cfg_ready is always high, and writes must be
// made while the block is idle; the block itself does not enforce this.
// Throughput: one item per cycle while item_stall is low. Each result passes
// the status stage with store read, the result queue and the output register,
// in that order.
// When the receiver stalls, the output holds and the four-entry queue fills;
// item_stall rises once the queue and the pending stage can take no more.
// Reset (synchronous, rst high) clears all message state, sets the length
// limit to 1024 and empties the queue; the store needs no clearing.
module ble_fragment_reassembler_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  bfr_pkg::in_item_t          item,
  output logic                       result_valid,
  input  logic                       result_stall,
  output bfr_pkg::out_item_t         result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [bfr_pkg::LEN_W-1:0]  cfg_data
);
  import bfr_pkg::*;

  logic              accept;
  ram_req_t          ram_req;
  logic [BYTE_W-1:0] ram_rdata;
  logic              pending;
  logic              push;
  out_item_t         push_item;
  logic              q_pop;
  logic              q_not_empty;
  out_item_t         q_head;
  logic [QUEUE_AW:0] q_level;

  // Stall while the queue cannot take another result plus the pending one.
  assign item_stall = ({1'b0, q_level} + {{QUEUE_AW{1'b0}}, 1'b0, pending})
                      >= (QUEUE_AW + 2)'(QUEUE_DEPTH);
  assign accept     = item_valid && !item_stall;
  assign cfg_ready  = 1'b1;

  bfr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .ram_rdata (ram_rdata),
    .ram_req   (ram_req),
    .pending   (pending),
    .push      (push),
    .push_item (push_item)
  );

  bfr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  bfr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head),
    .level     (q_level)
  );

  bfr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_not_empty  (q_not_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

/* bench/tb.sv */
// Self-checking testbench for the fragment reassembler unit.
// Depends on bfr_pkg and ble_fragment_reassembler_unit; drives directed and random
// packet and read traffic and checks every result against a local prediction or the directed table.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bfr_pkg::*;

  localparam int SETTLE_CYCLES = 10;
  localparam int HOLD_CYCLES   = 300;

  // One row of the directed table: the item and, where written out, its result.
  typedef struct packed {
    in_item_t  stim;
    logic      fixed;
    out_item_t want;
  } directed_row_t;

  logic             clk;
  logic             rst;
  logic             item_valid;
  logic             item_stall;
  in_item_t         item;
  logic             result_valid;
  logic             result_stall;
  out_item_t        result;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [LEN_W-1:0] cfg_data;

  ble_fragment_reassembler_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  // Predicted block state.
  logic [LEN_W-1:0]  max_len_cfg;
  bit                in_flight;
  logic [LEN_W-1:0]  exp_len;
  logic [BYTE_W-1:0] msg_tag;
  logic [LEN_W-1:0]  rx_count;
  logic [CNT_W-1:0]  pkt_count;
  logic [BYTE_W-1:0] hdr [FIRST_HEADER];
  bit                bank;
  logic [LEN_W-1:0]  done_len;
  logic [BYTE_W-1:0] store [STORE_DEPTH];

  // Results still owed by the block, oldest first.
  out_item_t pending_results [$];
  out_item_t monitor_want;

  // Bytes of the packet being built by the stimulus.
  logic [BYTE_W-1:0] pkt_bytes [$];

  int send_idle_pct = 31;
  int recv_idle_pct = 50;
  int hold_requests = 0;
  int mismatch_count = 0;
  int items_sent = 0;
  int reads_sent = 0;
  int results_checked = 0;
  int messages_completed = 0;
  int limits_used = 0;
  logic [15:0] status_seen = '0;

  directed_row_t directed_table [25];

  // Clock.
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void reset_prediction();
    max_len_cfg = MAX_LEN_RESET;
    in_flight   = 1'b0;
    exp_len     = '0;
    msg_tag     = '0;
    rx_count    = '0;
    pkt_count   = '0;
    bank        = 1'b0;
    done_len    = '0;
    foreach (hdr[n]) hdr[n] = '0;
    foreach (store[n]) store[n] = '0;
  endfunction

  function automatic int hdr_offset();
    return {hdr[1], hdr[0]};
  endfunction

  function automatic int hdr_length();
    return {hdr[4], hdr[3]};
  endfunction

  function automatic bit length_ok(input int len);
    return len != 0 && len <= int'(max_len_cfg) && len <= MAX_MESSAGE_BYTES;
  endfunction

  function automatic bit first_header_ok();
    return hdr_offset() == 0 && hdr[5] == FLAGS_NONE && length_ok(hdr_length());
  endfunction

  // A failed continuation drops the message and falls back to the completed bank.
  function automatic void drop_message();
    in_flight = 1'b0;
    bank      = ~bank;
  endfunction

  // Status of a packet of sz bytes whose header bytes are in hdr.
  function automatic logic [STAT_W-1:0] close_packet(input int sz,
                                                     output logic [LEN_W-1:0] len_out);
    int offset;
    int payload;
    int len;
    len_out = '0;
    if (sz < CONT_HEADER) return ST_SHORT;
    offset = hdr_offset();
    if (offset == 0) begin
      if (sz < FIRST_HEADER) return ST_SHORT;
      if (hdr[5] != FLAGS_NONE) return ST_FLAGS;
      len = hdr_length();
      if (!length_ok(len)) return ST_LENGTH;
      payload = sz - FIRST_HEADER;
      if (payload > len) return ST_FIRST_OVERRUN;
      if (in_flight) done_len = '0;
      msg_tag  = hdr[2];
      exp_len  = LEN_W'(len);
      rx_count = LEN_W'(payload);
      bank     = ~bank;
      if (payload == len) begin
        in_flight = 1'b0;
        done_len  = LEN_W'(len);
        len_out   = LEN_W'(len);
        return ST_COMPLETE;
      end
      in_flight = 1'b1;
      return ST_INCOMPLETE;
    end
    if (!in_flight) return ST_IDLE;
    if (hdr[2] != msg_tag) begin
      drop_message();
      return ST_ID;
    end
    if (offset != int'(rx_count)) begin
      drop_message();
      return ST_OFFSET;
    end
    payload = sz - CONT_HEADER;
    if (payload == 0) begin
      drop_message();
      return ST_EMPTY;
    end
    if (int'(rx_count) + payload > int'(exp_len)) begin
      drop_message();
      return ST_OVERRUN;
    end
    rx_count = LEN_W'(int'(rx_count) + payload);
    if (rx_count == exp_len) begin
      in_flight = 1'b0;
      done_len  = exp_len;
      len_out   = exp_len;
      return ST_COMPLETE;
    end
    return ST_INCOMPLETE;
  endfunction

  // Advances the predicted state by one item; returns 1 when the item yields a result.
  function automatic bit reassembler_predict(input in_item_t stim, output out_item_t res);
    int i;
    int pos;
    logic [LEN_W-1:0] len;
    res = '0;
    if (stim.kind == KIND_READ) begin
      res.result_kind = KIND_READ;
      if (stim.read_address < done_len)
        res.read_data = store[((bank ^ in_flight) ? MAX_MESSAGE_BYTES : 0) +
                              int'(stim.read_address)];
      return 1'b1;
    end

    // Header capture, then tentative writes of first-fragment payload.
    i = pkt_count;
    if (i < FIRST_HEADER) hdr[i] = stim.data_byte;
    if (i == FIRST_HEADER - 1 && in_flight && first_header_ok()) done_len = '0;
    if (i >= FIRST_HEADER && first_header_ok()) begin
      pos = i - FIRST_HEADER;
      if (pos < hdr_length())
        store[(bank ? 0 : MAX_MESSAGE_BYTES) + pos] = stim.data_byte;
    end

    // Continuation payload lands in the in-flight bank past the accepted bytes.
    if (i >= CONT_HEADER && in_flight && hdr_offset() != 0 && hdr[2] == msg_tag &&
        hdr_offset() == int'(rx_count)) begin
      pos = int'(rx_count) + i - CONT_HEADER;
      if (pos < int'(exp_len) && pos < MAX_MESSAGE_BYTES)
        store[(bank ? MAX_MESSAGE_BYTES : 0) + pos] = stim.data_byte;
    end
    if (pkt_count < COUNT_MAX) pkt_count = pkt_count + 1'b1;
    if (!stim.end_of_packet) return 1'b0;

    res.result_kind    = KIND_PACKET;
    res.status         = close_packet(int'(pkt_count), len);
    res.message_length = len;
    pkt_count          = '0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table helpers
  // ---------------------------------------------------------------------------

  function automatic directed_row_t pkt_row(input logic [BYTE_W-1:0] b, input logic eop,
                                            input logic fixed = 1'b0,
                                            input logic [STAT_W-1:0] st = ST_INCOMPLETE,
                                            input logic [LEN_W-1:0] len = '0);
    directed_row_t r;
    r = '0;
    r.stim.kind               = KIND_PACKET;
    r.stim.data_byte          = b;
    r.stim.end_of_packet      = eop;
    r.stim.read_address       = 10'h2AA;
    r.fixed                   = fixed;
    r.want.result_kind        = KIND_PACKET;
    r.want.status             = st;
    r.want.message_length     = len;
    return r;
  endfunction

  function automatic directed_row_t read_row(input logic [RADR_W-1:0] addr,
                                             input logic [BYTE_W-1:0] data,
                                             input logic fixed = 1'b1);
    directed_row_t r;
    r = '0;
    r.stim.kind          = KIND_READ;
    r.stim.data_byte     = 8'hFF;
    r.stim.end_of_packet = 1'b1;
    r.stim.read_address  = addr;
    r.fixed              = fixed;
    r.want.result_kind   = KIND_READ;
    r.want.read_data     = data;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Offers one item from a falling edge and returns at the falling edge after
  // the transaction. The expectation is recorded at the accepting edge.
  task automatic offer_item(input in_item_t stim, input logic has_fixed = 1'b0,
                            input out_item_t want = '0);
    out_item_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item       <= stim;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    items_sent++;
    if (stim.kind == KIND_READ) reads_sent++;
    if (reassembler_predict(stim, predicted)) begin
      if (predicted.result_kind == KIND_PACKET) begin
        status_seen[predicted.status] = 1'b1;
        if (predicted.status == ST_COMPLETE) messages_completed++;
      end
      pending_results.push_back(has_fixed ? want : predicted);
    end
    @(negedge clk);
  endtask

  task automatic send_packet();
    in_item_t stim;
    foreach (pkt_bytes[n]) begin
      stim.kind          = KIND_PACKET;
      stim.data_byte     = pkt_bytes[n];
      stim.end_of_packet = (n == pkt_bytes.size() - 1);
      stim.read_address  = RADR_W'($urandom_range(1023));
      offer_item(stim);
    end
  endtask

  task automatic send_read(input logic [RADR_W-1:0] addr);
    in_item_t stim;
    stim.kind          = KIND_READ;
    stim.data_byte     = BYTE_W'($urandom_range(255));
    stim.end_of_packet = 1'($urandom_range(1));
    stim.read_address  = addr;
    offer_item(stim);
  endtask

  // Mostly addresses inside the completed message, the first one past it included.
  function automatic logic [RADR_W-1:0] pick_read_addr();
    if (done_len != 0 && $urandom_range(99) < 75)
      return RADR_W'($urandom_range(int'(done_len)));
    return RADR_W'($urandom_range(1023));
  endfunction

  function automatic void start_first(input logic [BYTE_W-1:0] id, input int len,
                                      input logic [BYTE_W-1:0] flags);
    pkt_bytes.delete();
    pkt_bytes.push_back(8'h00);
    pkt_bytes.push_back(8'h00);
    pkt_bytes.push_back(id);
    pkt_bytes.push_back(len[7:0]);
    pkt_bytes.push_back(len[15:8]);
    pkt_bytes.push_back(flags);
  endfunction

  function automatic void start_cont(input int offset, input logic [BYTE_W-1:0] id);
    pkt_bytes.delete();
    pkt_bytes.push_back(offset[7:0]);
    pkt_bytes.push_back(offset[15:8]);
    pkt_bytes.push_back(id);
  endfunction

  function automatic void add_payload(input int n);
    repeat (n) pkt_bytes.push_back(BYTE_W'($urandom_range(255)));
  endfunction

  // Waits for the block to go quiet, sets the length limit and idling, then
  // runs random traffic until n_items more items have been taken.
  task automatic run_phase(input int limit, input int s_idle, input int r_idle,
                           input bit hold, input int n_items);
    int stop_at;
    int top;
    int len;
    int rcv;
    int chunk;
    int pick;
    int off;
    logic [BYTE_W-1:0] id;
    bit live;

    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_data  <= limit[LEN_W-1:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    max_len_cfg   = limit[LEN_W-1:0];
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    if (hold) hold_requests++;
    limits_used++;
    @(negedge clk);
    cfg_valid <= 1'b0;

    // A burst of reads fills the result path while the receiver holds off.
    if (hold) repeat (12) send_read(pick_read_addr());

    stop_at = items_sent + n_items;
    top = (limit < MAX_MESSAGE_BYTES) ? limit : MAX_MESSAGE_BYTES;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        // Well-formed message, sometimes broken or left hanging part way.
        pick = $urandom_range(99);
        if (pick < 6 && top <= 300) len = top;
        else if (pick < 85) len = $urandom_range((top < 24) ? top : 24, 1);
        else len = $urandom_range((top < 200) ? top : 200, 1);
        id  = BYTE_W'($urandom_range(255));
        rcv = $urandom_range(len, 1);
        start_first(id, len, FLAGS_NONE);
        add_payload(rcv);
        send_packet();
        live = 1'b1;
        while (live && rcv < len) begin
          // Side traffic between fragments.
          pick = $urandom_range(99);
          if (pick < 10) begin
            send_read(pick_read_addr());
          end else if (pick < 14) begin
            pkt_bytes.delete();
            add_payload($urandom_range(2, 1));
            send_packet();
          end else if (pick < 17) begin
            start_first(BYTE_W'($urandom_range(255)), $urandom_range(top, 1),
                        8'($urandom_range(255, 1)));
            send_packet();
          end else if (pick < 20) begin
            start_first(BYTE_W'($urandom_range(255)), 1, FLAGS_NONE);
            add_payload($urandom_range(3, 2));
            send_packet();
          end

          // Next fragment of the message.
          pick  = $urandom_range(99);
          chunk = $urandom_range(len - rcv, 1);
          if (chunk > 16 && $urandom_range(99) < 70) chunk = $urandom_range(16, 1);
          start_cont(rcv, id);
          if (pick < 4) begin
            pkt_bytes[2] = id ^ 8'($urandom_range(255, 1));
          end else if (pick < 8) begin
            off = rcv + $urandom_range(2000, 1);
            pkt_bytes[0] = off[7:0];
            pkt_bytes[1] = off[15:8];
          end
          if (pick >= 8 && pick < 11) chunk = 0;
          if (pick >= 11 && pick < 14) chunk = len - rcv + $urandom_range(4, 1);
          if (pick >= 14 && pick < 17) begin
            live = 1'b0;
          end else begin
            add_payload(chunk);
            send_packet();
            if (pick < 14) live = 1'b0;
            else rcv += chunk;
          end
        end
      end else if (pick < 70) begin
        repeat ($urandom_range(3, 1)) send_read(pick_read_addr());
      end else begin
        // Malformed and stray packets.
        case ($urandom_range(6))
          0: begin
            pkt_bytes.delete();
            len = $urandom_range(5, 1);
            add_payload(len);
            if (len >= 3 && $urandom_range(99) < 60) begin
              pkt_bytes[0] = 8'h00;
              pkt_bytes[1] = 8'h00;
            end
          end
          1: begin
            start_first(BYTE_W'($urandom_range(255)), $urandom_range(top, 1),
                        8'($urandom_range(255, 1)));
            add_payload($urandom_range(4));
          end
          2: begin
            pick = $urandom_range(2);
            if (pick == 0) len = 0;
            else if (pick == 1) len = limit + 1;
            else len = $urandom_range(65535, limit + 1);
            start_first(BYTE_W'($urandom_range(255)), len, FLAGS_NONE);
            add_payload($urandom_range(3));
          end
          3: begin
            len = $urandom_range((top < 8) ? top : 8, 1);
            start_first(BYTE_W'($urandom_range(255)), len, FLAGS_NONE);
            add_payload(len + $urandom_range(3, 1));
          end
          4: begin
            off = ($urandom_range(1)) ? $urandom_range(40, 1) : $urandom_range(65535, 1);
            start_cont(off, ($urandom_range(1)) ? msg_tag : 8'($urandom_range(255)));
            add_payload($urandom_range(6));
          end
          5: begin
            start_first(BYTE_W'($urandom_range(255)), top, FLAGS_NONE);
            add_payload($urandom_range(3));
          end
          default: begin
            pkt_bytes.delete();
            add_payload($urandom_range(12, 3));
          end
        endcase
        send_packet();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, and a long hold-off whenever one is requested.
  // ---------------------------------------------------------------------------

  initial begin : receiver
    int holds_served;
    int hold_left;
    holds_served = 0;
    hold_left    = 0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && holds_served < hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [15:0] want_v,
                                      input logic [15:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result %h arrived with none expected", $time, result);
        mismatch_count++;
      end else begin
        monitor_want = pending_results.pop_front();
        results_checked++;
        check_field("result_kind", monitor_want.result_kind, result.result_kind);
        check_field("status", monitor_want.status, result.status);
        check_field("message_length", monitor_want.message_length, result.message_length);
        check_field("read_data", monitor_want.read_data, result.read_data);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin : main
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    reset_prediction();

    // Directed items at the reset limit: empty store, short packet, stray
    // continuation, bad flags, then a two-fragment message read back.
    directed_table = '{
      read_row(10'd0, 8'h00),
      pkt_row(8'h00, 1'b0), pkt_row(8'hFF, 1'b1, 1'b1, ST_SHORT),
      pkt_row(8'h01, 1'b0), pkt_row(8'h00, 1'b0), pkt_row(8'h07, 1'b1, 1'b1, ST_IDLE),
      pkt_row(8'h00, 1'b0), pkt_row(8'h00, 1'b0), pkt_row(8'hAA, 1'b0),
      pkt_row(8'h00, 1'b0), pkt_row(8'h00, 1'b0), pkt_row(8'h80, 1'b1, 1'b1, ST_FLAGS),
      pkt_row(8'h00, 1'b0), pkt_row(8'h00, 1'b0), pkt_row(8'h5A, 1'b0),
      pkt_row(8'h02, 1'b0), pkt_row(8'h00, 1'b0), pkt_row(8'h00, 1'b0),
      pkt_row(8'hC3, 1'b1),
      pkt_row(8'h01, 1'b0), pkt_row(8'h00, 1'b0), pkt_row(8'h5A, 1'b0),
      pkt_row(8'h3C, 1'b1),
      read_row(10'd1, 8'h00, 1'b0),
      read_row(10'd1023, 8'h00)
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_table[n])
      offer_item(directed_table[n].stim, directed_table[n].fixed, directed_table[n].want);

    // Random phases: receiver-heavy idling, sender-heavy idling, then none.
    run_phase(1024, 31, 50, 1'b0, 150);
    run_phase(1, 31, 50, 1'b0, 60);
    run_phase(37, 50, 31, 1'b0, 150);
    run_phase(600, 50, 31, 1'b0, 130);
    run_phase(1023, 0, 0, 1'b1, 150);
    run_phase(200, 0, 0, 1'b0, 110);

    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d items (%0d reads) under %0d length limits; checked %0d results.",
             items_sent, reads_sent, limits_used, results_checked);
    $display("%0d messages completed; %0d of 11 packet status codes produced.",
             messages_completed, $countones(status_seen));
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog.
  initial begin : watchdog
    #1000000;
    $display("Timed out with %0d results outstanding", pending_results.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
